### rtl/core/abpa_pkg.sv
// shared types, constants and codes for the arena page bump allocator
`default_nettype none

package abpa_pkg;

  localparam int MAX_PAGES_DEF = 16;
  localparam int SIZE_W        = 17;
  localparam int INDEX_W       = 4;
  localparam int OFFSET_W      = 16;

  localparam logic [SIZE_W-1:0] PAGE_BYTES_RST = 17'd4096;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_ALLOC    = 2'd0,
    ST_TOO_BIG  = 2'd1,
    ST_NO_SPACE = 2'd2,
    ST_CLEARED  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESULT
  } state_t;

  typedef struct packed {
    status_t               status;
    logic [INDEX_W-1:0]    page_index;
    logic [OFFSET_W-1:0]   page_offset;
    logic                  opened_page;
  } result_t;

endpackage

`default_nettype wire

### rtl/core/abpa_ifs.sv
// handshake channels: request, response and configuration
`default_nettype none

interface abpa_req_if;
  import abpa_pkg::*;
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              arena_select;
  logic [SIZE_W-1:0] request_size;
  modport source (output valid, cmd, arena_select, request_size, input ready);
  modport sink   (input valid, cmd, arena_select, request_size, output ready);
endinterface

interface abpa_rsp_if;
  import abpa_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [INDEX_W-1:0]  page_index;
  logic [OFFSET_W-1:0] page_offset;
  logic                opened_page;
  modport source (output valid, status, page_index, page_offset, opened_page, input ready);
  modport sink   (input valid, status, page_index, page_offset, opened_page, output ready);
endinterface

interface abpa_cfg_if;
  import abpa_pkg::*;
  logic              valid;
  logic              ready;
  logic [SIZE_W-1:0] page_bytes;
  modport source (output valid, page_bytes, input ready);
  modport sink   (input valid, page_bytes, output ready);
endinterface

`default_nettype wire

### rtl/core/abpa_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none

module abpa_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/abpa_ctrl.sv
// allocation sequencer: first-fit scan over the page fill ram
`default_nettype none

module abpa_ctrl #(
  parameter int MAX_PAGES = abpa_pkg::MAX_PAGES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  abpa_req_if.sink                           req,
  input  wire logic [abpa_pkg::SIZE_W-1:0]   page_bytes,
  output abpa_pkg::result_t                  res,
  output logic                               res_valid,
  input  wire logic                          res_ready
);
  import abpa_pkg::*;

  localparam int CW = $clog2(MAX_PAGES + 1);
  localparam int AW = $clog2(2 * MAX_PAGES);

  state_t            state, state_next;
  logic              arena, arena_next;
  logic [SIZE_W-1:0] size, size_next;
  logic [CW-1:0]     used, used_next;
  logic [CW-1:0]     rd_cnt, rd_cnt_next;
  logic [CW-1:0]     chk_cnt, chk_cnt_next;
  logic              chk_valid, chk_valid_next;
  logic [CW-1:0]     pages_in_use [2];
  logic [CW-1:0]     pages_in_use_next [2];
  result_t           res_next;

  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [SIZE_W-1:0] mem_wdata, mem_rdata;

  logic [AW-1:0]     base, in_base;
  logic [CW-1:0]     in_used;
  logic [SIZE_W:0]   sum;
  logic              hit, last;

  abpa_ram #(
    .WIDTH (SIZE_W),
    .DEPTH (2 * MAX_PAGES)
  ) u_fill_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign base    = arena ? AW'(MAX_PAGES) : '0;
  assign in_base = req.arena_select ? AW'(MAX_PAGES) : '0;
  assign in_used = pages_in_use[req.arena_select];
  assign sum     = {1'b0, mem_rdata} + {1'b0, size};
  assign hit     = sum < {1'b0, page_bytes};
  assign last    = ({1'b0, chk_cnt} + 1'b1) == {1'b0, used};

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      chk_valid       <= 1'b0;
      pages_in_use[0] <= '0;
      pages_in_use[1] <= '0;
    end else begin
      state           <= state_next;
      chk_valid       <= chk_valid_next;
      pages_in_use[0] <= pages_in_use_next[0];
      pages_in_use[1] <= pages_in_use_next[1];
    end
  end

  always_ff @(posedge clk) begin
    arena   <= arena_next;
    size    <= size_next;
    used    <= used_next;
    rd_cnt  <= rd_cnt_next;
    chk_cnt <= chk_cnt_next;
    res     <= res_next;
  end

  always_comb begin
    state_next           = state;
    arena_next           = arena;
    size_next            = size;
    used_next            = used;
    rd_cnt_next          = rd_cnt;
    chk_cnt_next         = chk_cnt;
    chk_valid_next       = chk_valid;
    pages_in_use_next[0] = pages_in_use[0];
    pages_in_use_next[1] = pages_in_use[1];
    res_next             = res;
    mem_we               = 1'b0;
    mem_waddr            = '0;
    mem_wdata            = '0;
    mem_re               = 1'b0;
    mem_raddr            = '0;
    req.ready            = 1'b0;
    res_valid            = 1'b0;

    case (state)
      S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          arena_next = req.arena_select;
          size_next  = req.request_size;
          res_next   = '0;
          if (req.cmd == CMD_CLEAR) begin
            // fill entries are rewritten when a page opens, so no ram sweep
            pages_in_use_next[req.arena_select] = '0;
            res_next.status = ST_CLEARED;
            state_next      = S_RESULT;
          end else if (req.request_size > page_bytes) begin
            res_next.status = ST_TOO_BIG;
            state_next      = S_RESULT;
          end else if (in_used == '0) begin
            mem_we                 = 1'b1;
            mem_waddr              = in_base;
            mem_wdata              = req.request_size;
            pages_in_use_next[req.arena_select] = CW'(1);
            res_next.opened_page   = 1'b1;
            state_next             = S_RESULT;
          end else begin
            used_next      = in_used;
            rd_cnt_next    = '0;
            chk_valid_next = 1'b0;
            state_next     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // one read issued per cycle, the previous read checked alongside
        if (rd_cnt < used) begin
          mem_re      = 1'b1;
          mem_raddr   = base + AW'(rd_cnt);
          rd_cnt_next = rd_cnt + 1'b1;
        end
        chk_valid_next = rd_cnt < used;
        chk_cnt_next   = rd_cnt;
        if (chk_valid) begin
          if (hit) begin
            mem_we               = 1'b1;
            mem_waddr            = base + AW'(chk_cnt);
            mem_wdata            = sum[SIZE_W-1:0];
            res_next.page_index  = INDEX_W'(chk_cnt);
            res_next.page_offset = mem_rdata[OFFSET_W-1:0];
            chk_valid_next       = 1'b0;
            state_next           = S_RESULT;
          end else if (last) begin
            if (used < CW'(MAX_PAGES)) begin
              mem_we                   = 1'b1;
              mem_waddr                = base + AW'(used);
              mem_wdata                = size;
              pages_in_use_next[arena] = used + 1'b1;
              res_next.page_index      = INDEX_W'(used);
              res_next.opened_page     = 1'b1;
            end else begin
              res_next.status = ST_NO_SPACE;
            end
            chk_valid_next = 1'b0;
            state_next     = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  a_piu_bound: assert property (@(posedge clk) disable iff (rst)
    pages_in_use[0] <= CW'(MAX_PAGES) && pages_in_use[1] <= CW'(MAX_PAGES))
    else $error("page count beyond arena size");

  a_chk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && chk_valid) |-> chk_cnt < used)
    else $error("checked page outside pages in use");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready && req.cmd == CMD_CLEAR && !req.arena_select)
      |=> pages_in_use[0] == '0)
    else $error("clear left pages in the default arena");

  a_write_in_arena: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == S_SCAN) |-> ((mem_waddr - base) < AW'(MAX_PAGES)))
    else $error("fill write outside the selected arena");

endmodule

`default_nettype wire

### rtl/core/arena_page_bump_allocator.sv
// top level: config register, output register and the allocation sequencer
// clear, oversize and first-page requests go from S_IDLE straight to S_RESULT; other
//   allocations pass through S_SCAN, reading the fill ram for each page in use
// a new request is taken only after the last result word has moved into the output register
// reset: page counts of both arenas zeroed, page_bytes back to 4096, output empty;
//   the fill ram is not swept, entries are written when their page opens
`default_nettype none

module arena_page_bump_allocator #(
  parameter int MAX_PAGES = abpa_pkg::MAX_PAGES_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  abpa_cfg_if.sink   cfg,
  abpa_req_if.sink   req,
  abpa_rsp_if.source rsp
);
  import abpa_pkg::*;

  // page size register, shared by both arenas
  logic [SIZE_W-1:0] page_bytes;

  // result word from the sequencer
  result_t res;
  logic    res_valid;
  logic    res_ready;

  // configuration writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_bytes <= PAGE_BYTES_RST;
    end else if (cfg.valid) begin
      page_bytes <= cfg.page_bytes;
    end
  end

  abpa_ctrl #(
    .MAX_PAGES (MAX_PAGES)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .page_bytes (page_bytes),
    .res        (res),
    .res_valid  (res_valid),
    .res_ready  (res_ready)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (res_ready) begin
      rsp.valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp.status      <= res.status;
      rsp.page_index  <= res.page_index;
      rsp.page_offset <= res.page_offset;
      rsp.opened_page <= res.opened_page;
    end
  end

endmodule

`default_nettype wire

### tb/arena_page_bump_allocator_tb.sv
// self-checking testbench for the arena page bump allocator
`default_nettype none

module arena_page_bump_allocator_tb;
  import abpa_pkg::*;

  // cycles with no word moving on any channel before the run is called dead
  localparam int QUIET_LIMIT   = 2000;
  // long receiver hold-off, long enough to back the block up into its input
  localparam int HOLD_CYCLES   = 200;
  // settle time before a register write and before the final verdict
  localparam int SETTLE_CYCLES = 24;
  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;

  // keeps a private copy of both arenas and predicts each result word in order
  class alloc_scoreboard;
    logic [SIZE_W-1:0] page_bytes;
    logic [SIZE_W-1:0] fill [2][MAX_PAGES_DEF];
    int unsigned       open_pages [2];
    result_t           pending_results [$];
    int                mismatch_count;

    function new();
      page_bytes      = PAGE_BYTES_RST;
      open_pages[0]   = 0;
      open_pages[1]   = 0;
      mismatch_count  = 0;
    endfunction

    // first-fit over the open pages, else open the next page, else no space
    function void note_request(cmd_t cmd, logic arena, logic [SIZE_W-1:0] size);
      result_t     r;
      int unsigned used;
      bit          found;
      logic [SIZE_W:0] sum;
      r = '0;
      r.status = ST_ALLOC;
      found = 1'b0;
      used = open_pages[arena];
      if (cmd == CMD_CLEAR) begin
        for (int i = 0; i < MAX_PAGES_DEF; i++) fill[arena][i] = '0;
        open_pages[arena] = 0;
        r.status = ST_CLEARED;
      end else if (size > page_bytes) begin
        r.status = ST_TOO_BIG;
      end else begin
        for (int i = 0; i < used && !found; i++) begin
          sum = fill[arena][i] + size;
          if (sum < page_bytes) begin
            r.page_index  = INDEX_W'(i);
            r.page_offset = fill[arena][i][OFFSET_W-1:0];
            fill[arena][i] = sum[SIZE_W-1:0];
            found = 1'b1;
          end
        end
        if (!found) begin
          if (used < MAX_PAGES_DEF) begin
            r.page_index  = INDEX_W'(used);
            r.opened_page = 1'b1;
            fill[arena][used] = size;
            open_pages[arena] = used + 1;
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
      end
      pending_results.push_back(r);
    endfunction

    function void check_response(logic [1:0] status, logic [INDEX_W-1:0] idx,
                                 logic [OFFSET_W-1:0] off, logic opened);
      result_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with nothing expected, status %0d", $time, status);
        mismatch_count++;
        return;
      end
      want = pending_results.pop_front();
      if (want.status != status_t'(status)) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
        mismatch_count++;
      end
      if (want.page_index != idx) begin
        $display("%0t: page_index expected %0d actual %0d", $time, want.page_index, idx);
        mismatch_count++;
      end
      if (want.page_offset != off) begin
        $display("%0t: page_offset expected %0d actual %0d", $time, want.page_offset, off);
        mismatch_count++;
      end
      if (want.opened_page != opened) begin
        $display("%0t: opened_page expected %0d actual %0d", $time, want.opened_page,
                 opened);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  abpa_req_if req_ch ();
  abpa_rsp_if rsp_ch ();
  abpa_cfg_if cfg_ch ();

  arena_page_bump_allocator dut (
    .clk (clk),
    .rst (rst),
    .cfg (cfg_ch),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  alloc_scoreboard sb;
  int              hold_cycles = 0;
  int              quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // checking and watchdog, both on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      // one result word per accepted request, compared in order
      if (rsp_ch.valid && rsp_ch.ready)
        sb.check_response(rsp_ch.status, rsp_ch.page_index, rsp_ch.page_offset,
                          rsp_ch.opened_page);
      // any word moving on any channel counts as progress
      if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("arena_page_bump_allocator_tb NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: stall mode re-picked at random periodically, plus one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned rx_cycle;
    int unsigned stall_mode;
    rx_cycle   = 0;
    stall_mode = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (rx_cycle % 50 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        // long back-pressure stretch, counted down here
        rsp_ch.ready = 1'b0;
        hold_cycles--;
      end else begin
        case (stall_mode)
          0: rsp_ch.ready = 1'b1;                          // no stalls at all
          1: rsp_ch.ready = ($urandom_range(0, 3) != 0);   // light stalls
          2: rsp_ch.ready = 1'($urandom_range(0, 1));      // heavy stalls
          default: rsp_ch.ready = (rx_cycle % 5 != 0);     // periodic one-cycle stall
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // driving tasks, inputs change on the falling edge
  // ---------------------------------------------------------------------------
  // offer one request word and hold it until accepted
  task automatic send_word(cmd_t cmd, logic arena, logic [SIZE_W-1:0] size);
    @(negedge clk);
    req_ch.valid        = 1'b1;
    req_ch.cmd          = cmd;
    req_ch.arena_select = arena;
    req_ch.request_size = size;
    do @(posedge clk); while (!req_ch.ready);
    sb.note_request(cmd, arena, size);
  endtask

  task automatic idle_sender(int unsigned n);
    @(negedge clk);
    req_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // stop offering and wait for every outstanding result word
  task automatic drain_results();
    idle_sender(1);
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // page size is only changed with the block idle
  task automatic write_page_bytes(logic [SIZE_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid      = 1'b1;
    cfg_ch.page_bytes = value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.page_bytes = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  // sizes aimed at the interesting spots around the current page size
  function automatic logic [SIZE_W-1:0] pick_size(logic [SIZE_W-1:0] ps);
    int unsigned r;
    int unsigned top;
    r   = $urandom_range(0, 99);
    top = (ps == 0) ? 1 : ps;
    if (r < 8)       return SIZE_W'($urandom_range(0, SIZE_MAX));      // any bit pattern
    else if (r < 14) return ps;                                         // exactly a page
    else if (r < 18) return (ps == SIZE_MAX) ? ps : ps + 1'b1;          // one past a page
    else if (r < 22) return '0;
    else if (r < 60) return SIZE_W'($urandom_range(1, top / 4 + 1));    // packs a page
    else             return SIZE_W'($urandom_range(0, ps));
  endfunction

  // bursts of random requests with random gaps between them
  task automatic random_phase(int unsigned n_items);
    int unsigned left;
    int unsigned burst;
    cmd_t        cmd;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 20);
      if (burst > left) burst = left;
      repeat (burst) begin
        // clears are rare so the arenas get a chance to fill up
        cmd = ($urandom_range(0, 99) < 3) ? CMD_CLEAR : CMD_ALLOC;
        send_word(cmd, 1'($urandom_range(0, 1)), pick_size(sb.page_bytes));
      end
      left -= burst;
      if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 8));
    end
  endtask

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    logic [SIZE_W-1:0] phase_sizes [7];
    sb = new();
    rst                 = 1'b1;
    req_ch.valid        = 1'b0;
    req_ch.cmd          = CMD_ALLOC;
    req_ch.arena_select = 1'b0;
    req_ch.request_size = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.page_bytes   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part at the reset page size of 4096
    send_word(CMD_ALLOC, 1'b0, 17'd0);        // zero size opens page 0
    send_word(CMD_ALLOC, 1'b0, 17'd4096);     // a full page opens page 1
    send_word(CMD_ALLOC, 1'b0, 17'd4097);     // one byte too big
    send_word(CMD_ALLOC, 1'b0, SIZE_MAX);     // largest size field
    send_word(CMD_ALLOC, 1'b0, 17'd4095);     // fits page 0, fill reaches 4095
    send_word(CMD_ALLOC, 1'b0, 17'd1);        // 4095+1 is not below 4096, opens page 2
    send_word(CMD_ALLOC, 1'b0, 17'd4096);     // full page never takes more
    send_word(CMD_ALLOC, 1'b1, 17'd100);
    send_word(CMD_ALLOC, 1'b1, 17'd200);
    send_word(CMD_ALLOC, 1'b1, 17'd3795);     // 300+3795 just below the page
    send_word(CMD_ALLOC, 1'b1, 17'd1);        // 4095+1 is not below 4096, opens page 1
    send_word(CMD_ALLOC, 1'b1, 17'd65536);    // too big at this page size
    send_word(CMD_CLEAR, 1'b1, 17'd0);
    send_word(CMD_ALLOC, 1'b1, 17'd7);        // back to page 0 after the clear
    send_word(CMD_CLEAR, 1'b0, SIZE_MAX);     // size is ignored on a clear
    send_word(CMD_ALLOC, 1'b0, 17'd2048);
    idle_sender(3);

    // page sizes from the extremes of the register down to a tiny page
    phase_sizes[0] = 17'd4096;
    phase_sizes[1] = 17'd8;                   // fills all 16 pages fast, hits no space
    phase_sizes[2] = 17'd1;
    phase_sizes[3] = 17'd0;                   // only size 0 succeeds
    phase_sizes[4] = 17'd65536;
    phase_sizes[5] = SIZE_MAX;                // offsets wider than 16 bits get masked
    phase_sizes[6] = SIZE_W'($urandom_range(2, 600));

    foreach (phase_sizes[p]) begin
      write_page_bytes(phase_sizes[p]);
      random_phase(35);
      if (p == 1) begin
        // long receiver hold-off while the sender keeps offering back to back
        hold_cycles = HOLD_CYCLES;
        repeat (40)
          send_word(CMD_ALLOC, 1'($urandom_range(0, 1)), pick_size(sb.page_bytes));
      end
      if (p == 4) begin
        // sender pauses until every result word is back, then carries on
        drain_results();
      end
      random_phase(35);
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
      $display("arena_page_bump_allocator_tb OK");
    else
      $display("arena_page_bump_allocator_tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
